// ----- design/isp_pkg.sv -----
// isp_pkg: shared constants, request and status codes, and types for the sorted key store
// no dependencies; compile first

package isp_pkg;

   localparam int DEPTH   = 64;
   localparam int KEY_W   = 64;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int RIDX_W  = 6;
   localparam int POS_W   = 7;
   localparam int CODE_W  = 2;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [CNT_W-1:0]        count_type;

   typedef enum logic [CODE_W-1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_INSERT = 2'd1,
      REQ_READ   = 2'd2
   } req_code_type;

   typedef enum logic [CODE_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_BAD_INDEX = 2'd2
   } status_code_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic    insert_en;
      key_type new_key;
   } cell_ctl_type;

endpackage

// ----- design/isp_if.sv -----
// isp_req_if / isp_rsp_if: valid/ready channels for requests and results
// depends on isp_pkg

interface isp_req_if import isp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   req_type;
   key_type             key;
   logic [RIDX_W-1:0]   read_index;

   modport source (output valid, output req_type, output key, output read_index, input ready);
   modport sink   (input valid, input req_type, input key, input read_index, output ready);
endinterface

interface isp_rsp_if import isp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    position;
   key_type             read_key;
   logic [CODE_W-1:0]   status;

   modport source (output valid, output position, output read_key, output status, input ready);
   modport sink   (input valid, input position, input read_key, input status, output ready);
endinterface

// ----- design/isp_cell.sv -----
// isp_cell: one slot of the sorted row; compares its key and shifts right on insert
// depends on isp_pkg

module isp_cell import isp_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic         occupied,
   input  logic         left_le,
   input  key_type      left_key,
   output logic         le,
   output logic         slot_hit,
   output key_type      key_ff
);

   key_type key_in;

   // stored key <= new key, so the new key lands somewhere to the right
   assign le       = occupied && (key_ff <= ctl.new_key);
   assign slot_hit = left_le && !le;

   always_comb begin
      key_in = key_ff;
      if (ctl.insert_en && !le) begin
         key_in = left_le ? ctl.new_key : left_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

// ----- design/insertion_sorter_with_positions_core.sv -----
// insertion_sorter_with_positions_core: sorted store of signed keys kept in a row of cells
// depends on isp_pkg, isp_if (isp_req_if, isp_rsp_if) and isp_cell
//
// channel   dir   beat contents
// req_chan  in    req_type, key, read_index
// rsp_chan  out   position, read_key, status
//
// one request is taken per cycle unless a stalled result holds it; its result beat is ready the next cycle
// an insert compares against every cell and shifts the row in the same cycle
// a read selects the addressed cell through a mux into the result register
// reset clears the count and the result valid; cell contents stay undefined
// a stalled result stalls requests only while the result register is still occupied

module insertion_sorter_with_positions_core import isp_pkg::*; (
   input logic      clock,
   input logic      reset,
   isp_req_if.sink   req_chan,
   isp_rsp_if.source rsp_chan
);

   // element count
   count_type count_ff, count_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] position_ff, position_in;
   key_type          read_key_ff, read_key_in;
   logic [CODE_W-1:0] status_ff, status_in;

   // row of cells
   cell_ctl_type          ctl;
   logic    [DEPTH-1:0]   occupied;
   logic    [DEPTH-1:0]   le;
   logic    [DEPTH-1:0]   slot_hit;
   logic    [DEPTH-1:0]   left_le;
   key_type               cell_key [DEPTH];
   key_type               left_key [DEPTH];

   logic      accept;
   logic      full;
   count_type slot_pos;
   key_type   sel_key;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CNT_W'(DEPTH));

   assign ctl.insert_en = accept && (req_chan.req_type == REQ_INSERT) && !full;
   assign ctl.new_key   = req_chan.key;

   // cell 0 has nothing to its left, so it always counts as "left is <= key"
   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         assign occupied[g] = (count_ff > CNT_W'(g));
         if (g == 0) begin : g_first
            assign left_le[g]  = 1'b1;
            assign left_key[g] = ctl.new_key;
         end else begin : g_rest
            assign left_le[g]  = le[g-1];
            assign left_key[g] = cell_key[g-1];
         end
         isp_cell u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .occupied (occupied[g]),
            .left_le  (left_le[g]),
            .left_key (left_key[g]),
            .le       (le[g]),
            .slot_hit (slot_hit[g]),
            .key_ff   (cell_key[g])
         );
      end
   endgenerate

   // slot_hit is one-hot when not full; encode it as a 1-based position
   always_comb begin
      slot_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         slot_pos = slot_pos | (slot_hit[i] ? CNT_W'(i + 1) : '0);
      end
   end

   // read mux over the cells
   always_comb begin
      sel_key = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (int'(req_chan.read_index) == i) begin
            sel_key = cell_key[i];
         end
      end
   end

   // next count
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (req_chan.req_type)
            REQ_CLEAR:  count_in = '0;
            REQ_INSERT: if (!full) count_in = count_ff + 1'b1;
            default:    count_in = count_ff;
         endcase
      end
   end

   // next result beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      position_in  = position_ff;
      read_key_in  = read_key_ff;
      status_in    = status_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         position_in  = '0;
         read_key_in  = '0;
         status_in    = STAT_OK;
         case (req_chan.req_type)
            REQ_INSERT: begin
               if (full) status_in = STAT_FULL;
               else      position_in = POS_W'(slot_pos);
            end
            REQ_READ: begin
               if (int'(req_chan.read_index) < int'(count_ff)) read_key_in = sel_key;
               else                                          status_in   = STAT_BAD_INDEX;
            end
            default: begin
               status_in = STAT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      position_ff <= position_in;
      read_key_ff <= read_key_in;
      status_ff   <= status_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.position = position_ff;
   assign rsp_chan.read_key = read_key_ff;
   assign rsp_chan.status   = status_ff;

`ifndef SYNTHESIS
   // the count never runs past the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count beyond depth");

   // a live insert finds exactly one landing cell
   a_slot_onehot: assert property (@(posedge clock) disable iff (reset)
      ctl.insert_en |-> $onehot(slot_hit))
      else $error("insert landing slot not one-hot");

   // an accepted insert into a non-full store grows the count by one
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      ctl.insert_en |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not advance on insert");

   // a full-store result never carries a position or a key
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STAT_FULL) |-> (position_ff == '0 && read_key_ff == '0))
      else $error("dropped insert reported data");
`endif

endmodule
